// ----- rtl/core/tsa_pkg.sv -----
// Shared constants, codes and types of the tween slot animator.
// Depends on nothing; the controller, the datapath and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

   localparam int SLOTS      = 10;
   localparam int PROPERTIES = 16;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int PROP_W     = 4;
   localparam int DIV_STEPS  = 30;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [PROP_W:0] PROP_LIMIT = (PROP_W + 1)'(PROPERTIES);

   localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [31:0] HALF_Q30 = 32'h2000_0000;
   localparam logic [31:0] TWO_Q30  = 32'h8000_0000;

   localparam logic [2:0] CURVE_LINEAR = 3'd0;
   localparam logic [2:0] CURVE_FAST   = 3'd1;
   localparam logic [2:0] CURVE_DFAST  = 3'd2;
   localparam logic [2:0] CURVE_SLOW   = 3'd3;
   localparam logic [2:0] CURVE_DSLOW  = 3'd4;
   localparam logic [2:0] CURVE_INOUT  = 3'd5;
   localparam logic [2:0] CURVE_BOUNCE = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_ADD_DONE,
      ST_TICK_MASK,
      ST_TICK_SEL,
      ST_TICK_FIN,
      ST_TICK_IDLE,
      ST_DIV,
      ST_EASE0,
      ST_EASE1,
      ST_EASE2,
      ST_EASE3,
      ST_BLEND1,
      ST_BLEND2
   } state_type;

   typedef struct packed {
      logic capture;
      logic add_scan;
      logic add_done;
      logic tick_mask;
      logic slot_inc;
      logic div_start;
      logic div_step;
      logic ease0;
      logic ease1;
      logic ease2;
      logic ease3;
      logic blend1;
      logic load_blend;
      logic load_fin;
      logic load_idle;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic mask_any;
      logic mask_bit;
      logic fin_now;
      logic is_last;
      logic slot_last;
      logic div_last;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/tsa_req_if.sv -----
// Request channel of the tween slot animator: valid, ready and the request fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tsa_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [31:0]        now;
   logic [3:0]         property_req;
   logic signed [31:0] start_value;
   logic signed [31:0] end_value;
   logic [2:0]         curve;
   logic [15:0]        delay_ms;
   logic [15:0]        duration_ms;

   modport source (output valid, mode, now, property_req, start_value, end_value, curve,
                   delay_ms, duration_ms, input ready);
   modport sink (input valid, mode, now, property_req, start_value, end_value, curve,
                 delay_ms, duration_ms, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tsa_rsp_if.sv -----
// Result channel of the tween slot animator: valid, ready and the result fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tsa_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         out_property;
   logic signed [31:0] out_value;
   logic               updated;
   logic               finished;
   logic               table_full;
   logic               last;

   modport source (output valid, out_property, out_value, updated, finished, table_full,
                   last, input ready);
   modport sink (input valid, out_property, out_value, updated, finished, table_full,
                 last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tsa_ctrl.sv -----
// Controller state machine of the tween slot animator.
// Depends on tsa_pkg; drives the datapath through cmd_type and reads stat_type.
`timescale 1ns / 1ps
`default_nettype none

module tsa_ctrl
   import tsa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_mode,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_mode ? ST_TICK_MASK : ST_ADD_SCAN;
            end
         end
         ST_ADD_SCAN: begin
            if (stat.slot_last) state_in = ST_ADD_DONE;
         end
         ST_ADD_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_TICK_MASK: state_in = ST_TICK_SEL;
         ST_TICK_SEL: begin
            if (!stat.mask_any) begin
               state_in = ST_TICK_IDLE;
            end else if (stat.mask_bit) begin
               state_in = stat.fin_now ? ST_TICK_FIN : ST_DIV;
            end
         end
         ST_TICK_IDLE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_TICK_FIN: begin
            if (stat.out_free) state_in = stat.is_last ? ST_IDLE : ST_TICK_SEL;
         end
         ST_DIV: begin
            if (stat.div_last) state_in = ST_EASE0;
         end
         ST_EASE0:  state_in = ST_EASE1;
         ST_EASE1:  state_in = ST_EASE2;
         ST_EASE2:  state_in = ST_EASE3;
         ST_EASE3:  state_in = ST_BLEND1;
         ST_BLEND1: state_in = ST_BLEND2;
         ST_BLEND2: begin
            if (stat.out_free) state_in = stat.is_last ? ST_IDLE : ST_TICK_SEL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_ADD_SCAN: begin
            cmd.add_scan = 1'b1;
            cmd.slot_inc = 1'b1;
         end
         ST_ADD_DONE:  cmd.add_done  = stat.out_free;
         ST_TICK_MASK: cmd.tick_mask = 1'b1;
         ST_TICK_SEL: begin
            if (stat.mask_any) begin
               if (!stat.mask_bit) begin
                  cmd.slot_inc = 1'b1;
               end else if (!stat.fin_now) begin
                  cmd.div_start = 1'b1;
               end
            end
         end
         ST_TICK_IDLE: cmd.load_idle = stat.out_free;
         ST_TICK_FIN: begin
            cmd.load_fin = stat.out_free;
            cmd.slot_inc = stat.out_free & ~stat.is_last;
         end
         ST_DIV:    cmd.div_step = 1'b1;
         ST_EASE0:  cmd.ease0    = 1'b1;
         ST_EASE1:  cmd.ease1    = 1'b1;
         ST_EASE2:  cmd.ease2    = 1'b1;
         ST_EASE3:  cmd.ease3    = 1'b1;
         ST_BLEND1: cmd.blend1   = 1'b1;
         ST_BLEND2: begin
            cmd.load_blend = stat.out_free;
            cmd.slot_inc   = stat.out_free & ~stat.is_last;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/tsa_datapath.sv -----
// Datapath of the tween slot animator: slot table, divider, easing multiplier and result register.
// Depends on tsa_pkg; steered by tsa_ctrl through cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module tsa_datapath
   import tsa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   input  wire logic [31:0]        req_now,
   input  wire logic [3:0]         req_property,
   input  wire logic signed [31:0] req_start_value,
   input  wire logic signed [31:0] req_end_value,
   input  wire logic [2:0]         req_curve,
   input  wire logic [15:0]        req_delay_ms,
   input  wire logic [15:0]        req_duration_ms,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [3:0]              rsp_property,
   output logic signed [31:0]      rsp_value,
   output logic                    rsp_updated,
   output logic                    rsp_finished,
   output logic                    rsp_table_full,
   output logic                    rsp_last
);

   logic [SLOTS-1:0]  active_ff;
   logic [PROP_W-1:0] prop_ff  [SLOTS];
   logic [31:0]       sval_ff  [SLOTS];
   logic [31:0]       eval_ff  [SLOTS];
   logic [2:0]        curve_ff [SLOTS];
   logic [31:0]       stime_ff [SLOTS];
   logic [31:0]       etime_ff [SLOTS];

   logic [31:0]       now_ff;
   logic [PROP_W-1:0] rprop_ff;
   logic [31:0]       rsv_ff;
   logic [31:0]       rev_ff;
   logic [2:0]        rcurve_ff;
   logic [31:0]       st_ff;
   logic [15:0]       dur_ff;

   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOTS-1:0]     mask_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [31:0]          rem_ff;
   logic [31:0]          len_ff;
   logic [29:0]          q_ff;
   logic [31:0]          u_ff;
   logic [31:0]          d_ff;
   logic [29:0]          bc_ff;
   logic [31:0]          mag_ff;
   logic                 neg_ff;
   logic [63:0]          prod_ff;
   logic [63:0]          p1_ff;
   logic [30:0]          c_ff;

   logic                 out_valid_ff;
   logic [PROP_W-1:0]    out_prop_ff;
   logic [31:0]          out_value_ff;
   logic                 out_upd_ff;
   logic                 out_fin_ff;
   logic                 out_full_ff;
   logic                 out_last_ff;

   logic [31:0]       cur_start;
   logic [31:0]       cur_end;
   logic [2:0]        cur_curve;
   logic [31:0]       dt;
   logic [31:0]       len;
   logic              prop_ok;
   logic              match;
   logic [31:0]       new_end;
   logic              free_any;
   logic [SLOT_W-1:0] free_idx;
   logic [32:0]       st_sum;
   logic [31:0]       st_sat;
   logic [32:0]       et_sum;
   logic [31:0]       et_sat;
   logic              more;
   logic [32:0]       div_sh;
   logic              div_ge;
   logic [31:0]       t_ext;
   logic [33:0]       w;
   logic [33:0]       bk;
   logic [29:0]       bc;
   logic [33:0]       bd;
   logic [32:0]       rng;
   logic [32:0]       rng_abs;
   logic [31:0]       mul_a;
   logic [31:0]       mul_b;
   logic [33:0]       q1;
   logic [33:0]       q2;
   logic [35:0]       r;
   logic [63:0]       rnd;
   logic [35:0]       v;
   logic [31:0]       blend_val;
   logic              load_any;

   assign cur_start = stime_ff[slot_ff];
   assign cur_end   = etime_ff[slot_ff];
   assign cur_curve = curve_ff[slot_ff];
   assign dt        = now_ff - cur_start;
   assign len       = (cur_end > cur_start) ? (cur_end - cur_start) : 32'd0;
   assign prop_ok   = {1'b0, rprop_ff} < PROP_LIMIT;
   assign match     = active_ff[slot_ff] && (prop_ff[slot_ff] == rprop_ff) && prop_ok;
   assign new_end   = (cur_end > st_ff) ? st_ff : cur_end;

   assign st_sum = {1'b0, req_now} + {17'd0, req_delay_ms};
   assign st_sat = st_sum[32] ? 32'hFFFF_FFFF : st_sum[31:0];
   assign et_sum = {1'b0, st_ff} + {17'd0, dur_ff};
   assign et_sat = et_sum[32] ? 32'hFFFF_FFFF : et_sum[31:0];

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      more = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if ((i > int'(slot_ff)) && mask_ff[i]) more = 1'b1;
      end
   end

   assign div_sh = {rem_ff, 1'b0};
   assign div_ge = div_sh >= {1'b0, len_ff};

   assign t_ext = {2'b00, q_ff};
   assign w     = ({4'd0, q_ff} << 3) + ({4'd0, q_ff} << 1) + {4'd0, q_ff};

   always_comb begin
      if (w < 34'h1_0000_0000) begin
         bk = 34'd0;
         bc = 30'd0;
      end else if (w < 34'h2_0000_0000) begin
         bk = 34'h1_8000_0000;
         bc = 30'h3000_0000;
      end else if (w < 34'h2_8000_0000) begin
         bk = 34'h2_4000_0000;
         bc = 30'h3C00_0000;
      end else begin
         bk = 34'h2_A000_0000;
         bc = 30'h3F00_0000;
      end
      bd = (w >= bk) ? (w - bk) : (bk - w);
   end

   assign rng     = {eval_ff[slot_ff][31], eval_ff[slot_ff]}
                  - {sval_ff[slot_ff][31], sval_ff[slot_ff]};
   assign rng_abs = rng[32] ? (33'd0 - rng) : rng;

   always_comb begin
      case (cur_curve)
         CURVE_FAST: begin
            mul_a = t_ext;
            mul_b = TWO_Q30 - t_ext;
         end
         CURVE_DFAST: begin
            mul_a = u_ff;
            mul_b = u_ff;
         end
         CURVE_INOUT: begin
            mul_a = (t_ext < HALF_Q30) ? t_ext : u_ff;
            mul_b = mul_a;
         end
         CURVE_BOUNCE: begin
            mul_a = d_ff;
            mul_b = d_ff;
         end
         default: begin
            mul_a = t_ext;
            mul_b = t_ext;
         end
      endcase
   end

   assign q1 = p1_ff[63:30];
   assign q2 = prod_ff[63:30];

   always_comb begin
      case (cur_curve)
         CURVE_LINEAR: r = {4'd0, t_ext};
         CURVE_FAST:   r = {2'd0, q1};
         CURVE_DFAST:  r = {4'd0, ONE_Q30} - {2'd0, q2};
         CURVE_SLOW:   r = {2'd0, q1};
         CURVE_DSLOW:  r = {2'd0, q2};
         CURVE_INOUT: begin
            if (t_ext < HALF_Q30) r = {1'b0, q1, 1'b0};
            else                  r = {4'd0, ONE_Q30} - {1'b0, q1, 1'b0};
         end
         CURVE_BOUNCE: r = {6'd0, p1_ff[63:34]} + {6'd0, bc_ff};
         default:      r = 36'd0;
      endcase
   end

   assign rnd = prod_ff + {34'd0, HALF_Q30[29:0]};

   always_comb begin
      if (neg_ff) begin
         v = {{4{sval_ff[slot_ff][31]}}, sval_ff[slot_ff]} - {2'd0, rnd[63:30]};
      end else begin
         v = {{4{sval_ff[slot_ff][31]}}, sval_ff[slot_ff]} + {2'd0, rnd[63:30]};
      end
      if (!v[35] && (v[34:31] != 4'd0)) begin
         blend_val = 32'h7FFF_FFFF;
      end else if (v[35] && (v[34:31] != 4'hF)) begin
         blend_val = 32'h8000_0000;
      end else begin
         blend_val = v[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         if (cmd.add_scan && match && (cur_start >= st_ff || cur_start >= new_end)) begin
            active_ff[slot_ff] <= 1'b0;
         end
         if (cmd.add_done && prop_ok && free_any) begin
            active_ff[free_idx] <= 1'b1;
         end
         if (cmd.load_fin) begin
            active_ff[slot_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_scan && match && (cur_end > st_ff)) begin
         etime_ff[slot_ff] <= st_ff;
         eval_ff[slot_ff]  <= rsv_ff;
      end
      if (cmd.add_done && prop_ok && free_any) begin
         prop_ff[free_idx]  <= rprop_ff;
         sval_ff[free_idx]  <= rsv_ff;
         eval_ff[free_idx]  <= rev_ff;
         curve_ff[free_idx] <= rcurve_ff;
         stime_ff[free_idx] <= st_ff;
         etime_ff[free_idx] <= et_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff    <= req_now;
         rprop_ff  <= req_property;
         rsv_ff    <= req_start_value;
         rev_ff    <= req_end_value;
         rcurve_ff <= req_curve;
         st_ff     <= st_sat;
         dur_ff    <= req_duration_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (cmd.capture) begin
         slot_ff <= '0;
      end else if (cmd.slot_inc) begin
         slot_ff <= stat.slot_last ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_mask) begin
         for (int i = 0; i < SLOTS; i++) begin
            mask_ff[i] <= active_ff[i] && (now_ff >= stime_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= dt;
         len_ff <= len;
         q_ff   <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= 32'(div_sh - {1'b0, len_ff});
            q_ff   <= {q_ff[28:0], 1'b1};
         end else begin
            rem_ff <= div_sh[31:0];
            q_ff   <= {q_ff[28:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ease0) begin
         u_ff   <= ONE_Q30 - t_ext;
         d_ff   <= bd[31:0];
         bc_ff  <= bc;
         mag_ff <= rng_abs[31:0];
         neg_ff <= rng[32];
      end
      if (cmd.ease1) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.ease2) begin
         p1_ff   <= prod_ff;
         prod_ff <= prod_ff[61:30] * ((cur_curve == CURVE_DFAST) ? u_ff : t_ext);
      end
      if (cmd.ease3) begin
         c_ff <= (r > {4'd0, ONE_Q30}) ? ONE_Q30[30:0] : r[30:0];
      end
      if (cmd.blend1) begin
         prod_ff <= mag_ff * {1'b0, c_ff};
      end
   end

   assign load_any = cmd.add_done | cmd.load_fin | cmd.load_idle | cmd.load_blend;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_any) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_done) begin
         out_prop_ff  <= rprop_ff;
         out_value_ff <= 32'd0;
         out_upd_ff   <= 1'b0;
         out_fin_ff   <= 1'b0;
         out_full_ff  <= prop_ok & ~free_any;
         out_last_ff  <= 1'b1;
      end else if (cmd.load_idle) begin
         out_prop_ff  <= '0;
         out_value_ff <= 32'd0;
         out_upd_ff   <= 1'b0;
         out_fin_ff   <= 1'b0;
         out_full_ff  <= 1'b0;
         out_last_ff  <= 1'b1;
      end else if (cmd.load_fin) begin
         out_prop_ff  <= prop_ff[slot_ff];
         out_value_ff <= eval_ff[slot_ff];
         out_upd_ff   <= 1'b1;
         out_fin_ff   <= 1'b1;
         out_full_ff  <= 1'b0;
         out_last_ff  <= ~more;
      end else if (cmd.load_blend) begin
         out_prop_ff  <= prop_ff[slot_ff];
         out_value_ff <= blend_val;
         out_upd_ff   <= 1'b1;
         out_fin_ff   <= 1'b0;
         out_full_ff  <= 1'b0;
         out_last_ff  <= ~more;
      end
   end

   always_comb begin
      stat.out_free  = ~out_valid_ff | rsp_ready;
      stat.mask_any  = |mask_ff;
      stat.mask_bit  = mask_ff[slot_ff];
      stat.fin_now   = (len == 32'd0) || (dt >= len);
      stat.is_last   = ~more;
      stat.slot_last = slot_ff == SLOT_W'(SLOTS - 1);
      stat.div_last  = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_property   = out_prop_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_updated    = out_upd_ff;
   assign rsp_finished   = out_fin_ff;
   assign rsp_table_full = out_full_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tween_slot_animator.sv -----
// Top level of the tween slot animator: joins the controller and the datapath to the channels.
// Depends on tsa_pkg, tsa_req_if, tsa_rsp_if, tsa_ctrl and tsa_datapath.
//
// The block works on one request at a time. An add request walks the ten slots one per cycle
// to trim or cancel older animations of the same property, then stores the new one in the
// lowest free slot once the result channel is free. A tick request first builds the list of
// started slots, then passes over each slot that is not in the list, frees a slot that finishes
// and reports its end value, and interpolates every other listed slot with the thirty-step
// restoring divider and the multiplications that evaluate the curve and the blend.
`timescale 1ns / 1ps
`default_nettype none

module tween_slot_animator
   import tsa_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tsa_req_if.sink   req_chan,
   tsa_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   tsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tsa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_now         (req_chan.now),
      .req_property    (req_chan.property_req),
      .req_start_value (req_chan.start_value),
      .req_end_value   (req_chan.end_value),
      .req_curve       (req_chan.curve),
      .req_delay_ms    (req_chan.delay_ms),
      .req_duration_ms (req_chan.duration_ms),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_property    (rsp_chan.out_property),
      .rsp_value       (rsp_chan.out_value),
      .rsp_updated     (rsp_chan.updated),
      .rsp_finished    (rsp_chan.finished),
      .rsp_table_full  (rsp_chan.table_full),
      .rsp_last        (rsp_chan.last)
   );

endmodule

`default_nettype wire
